/* rtl/core/hff_pkg.sv */
// Shared types, constants and character helpers of the hex field formatter.
package hff_pkg;

  localparam int MAX_RUN = 64;

  // Field widths fixed by the interface.
  localparam int ValueW = 64;
  localparam int WidthW = 7;
  localparam int PrecW  = 6;
  localparam int IndexW = 6;
  localparam int NdigW  = 5;

  localparam logic [WidthW-1:0] WidthMax = WidthW'(MAX_RUN);
  localparam logic [PrecW-1:0]  PrecMax  = PrecW'(MAX_RUN - 2);

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChXLow  = 8'h78;
  localparam logic [7:0] ChXUp   = 8'h58;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COUNT,
    ST_PLAN,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic load;
    logic count;
    logic plan;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic last;
    logic slot_free;
  } stat_t;

  function automatic logic [7:0] hex_ascii(input logic [3:0] nib, input logic upper);
    logic [7:0] ch;
    if (nib < 4'd10) begin
      ch = ChZero + {4'b0, nib};
    end else if (upper) begin
      ch = 8'h41 + {4'b0, nib - 4'd10};
    end else begin
      ch = 8'h61 + {4'b0, nib - 4'd10};
    end
    return ch;
  endfunction

endpackage

/* rtl/core/hff_ctrl.sv */
// Sequencing state machine of the hex field formatter.
module hff_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  hff_pkg::stat_t stat,
  output hff_pkg::cmd_t  cmd
);

  hff_pkg::state_t state_r;
  hff_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hff_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      hff_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = hff_pkg::ST_COUNT;
        end
      end
      hff_pkg::ST_COUNT: begin
        cmd.count = 1'b1;
        state_nxt = hff_pkg::ST_PLAN;
      end
      hff_pkg::ST_PLAN: begin
        cmd.plan  = 1'b1;
        state_nxt = stat.empty ? hff_pkg::ST_IDLE : hff_pkg::ST_RUN;
      end
      hff_pkg::ST_RUN: begin
        if (stat.slot_free) begin
          cmd.emit = 1'b1;
          if (stat.last) begin
            state_nxt = hff_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = hff_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/hff_datapath.sv */
// Operand registers, field layout arithmetic and output register of the formatter.
module hff_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  hff_pkg::cmd_t                cmd,
  output hff_pkg::stat_t               stat,
  input  logic [hff_pkg::ValueW-1:0]   in_value,
  input  logic [hff_pkg::WidthW-1:0]   in_field_width,
  input  logic [hff_pkg::PrecW-1:0]    in_precision,
  input  logic                         in_has_precision,
  input  logic                         in_pad_with_zero,
  input  logic                         in_alternate_form,
  input  logic                         in_sign_slot,
  input  logic                         in_upper_case,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [7:0]                   out_out_char,
  output logic [hff_pkg::IndexW-1:0]   out_char_index,
  output logic                         out_is_last
);

  // Operands captured at acceptance, limits already applied.
  logic [hff_pkg::ValueW-1:0] value_r;
  logic [hff_pkg::WidthW-1:0] width_r;
  logic [hff_pkg::PrecW-1:0]  prec_r;
  logic dot_r, zero_r, sharp_r, sign_r, upper_r;

  // Results of the count step.
  logic [hff_pkg::NdigW-1:0] ndig_r;
  logic [hff_pkg::PrecW-1:0] body_r;
  logic                      pre_r;

  // Results of the plan step.
  logic [hff_pkg::WidthW-1:0] len_r, ps_r, dstart_r;
  logic [hff_pkg::IndexW-1:0] idx_r;

  logic                       out_valid_r;
  logic [7:0]                 out_char_r;
  logic [hff_pkg::IndexW-1:0] out_index_r;
  logic                       out_last_r;

  logic [hff_pkg::NdigW-1:0]  ndig_c;
  logic [hff_pkg::PrecW-1:0]  b0_c, body_c;
  logic                       prefix_c;
  logic [7:0]                 total_c;
  logic [hff_pkg::WidthW-1:0] pad_c, len_c, dstart_c, ps_c;
  logic [hff_pkg::NdigW-1:0]  dcnt_c;
  logic [hff_pkg::WidthW-1:0] idx_w, rem_c;
  logic [3:0]                 nib_c;
  logic [7:0]                 char_c;
  logic                       last_c;

  // Count step: number of significant nibbles and digit body length.
  always_comb begin
    ndig_c = hff_pkg::NdigW'(1);
    for (int k = 1; k < hff_pkg::ValueW / 4; k++) begin
      if (value_r[4*k +: 4] != 4'd0) begin
        ndig_c = hff_pkg::NdigW'(k + 1);
      end
    end
    if (dot_r && (prec_r == '0) && (value_r == '0)) begin
      b0_c = '0;
    end else begin
      b0_c = {1'b0, ndig_c};
    end
    body_c   = (prec_r > b0_c) ? prec_r : b0_c;
    prefix_c = sharp_r && (value_r != '0);
  end

  // Plan step: padding, run length and segment boundaries.
  always_comb begin
    total_c  = {1'b0, width_r} - {2'b0, body_r} - {7'b0, sign_r} - {6'b0, pre_r, 1'b0};
    pad_c    = total_c[7] ? '0 : total_c[6:0];
    len_c    = pad_c + {5'b0, pre_r, 1'b0} + {1'b0, body_r};
    dcnt_c   = (body_r != '0) ? ndig_r : '0;
    dstart_c = len_c - {2'b0, dcnt_c};
    ps_c     = zero_r ? '0 : pad_c;
  end

  // Character at the current run position.
  always_comb begin
    idx_w  = {1'b0, idx_r};
    rem_c  = len_r - hff_pkg::WidthW'(1) - idx_w;
    nib_c  = value_r[{rem_c[3:0], 2'b00} +: 4];
    last_c = (idx_w + hff_pkg::WidthW'(1)) == len_r;
    if (idx_w < ps_r) begin
      char_c = hff_pkg::ChSpace;
    end else if (pre_r && (idx_w == ps_r)) begin
      char_c = hff_pkg::ChZero;
    end else if (pre_r && (idx_w == ps_r + hff_pkg::WidthW'(1))) begin
      char_c = upper_r ? hff_pkg::ChXUp : hff_pkg::ChXLow;
    end else if (idx_w >= dstart_r) begin
      char_c = hff_pkg::hex_ascii(nib_c, upper_r);
    end else begin
      char_c = hff_pkg::ChZero;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value_r <= in_value;
      width_r <= (in_field_width > hff_pkg::WidthMax) ? hff_pkg::WidthMax : in_field_width;
      prec_r  <= (in_precision > hff_pkg::PrecMax) ? hff_pkg::PrecMax : in_precision;
      dot_r   <= in_has_precision;
      zero_r  <= in_pad_with_zero;
      sharp_r <= in_alternate_form;
      sign_r  <= in_sign_slot;
      upper_r <= in_upper_case;
    end
    if (cmd.count) begin
      ndig_r <= ndig_c;
      body_r <= body_c;
      pre_r  <= prefix_c;
    end
    if (cmd.plan) begin
      len_r    <= len_c;
      ps_r     <= ps_c;
      dstart_r <= dstart_c;
      idx_r    <= '0;
    end else if (cmd.emit) begin
      idx_r <= idx_r + hff_pkg::IndexW'(1);
    end
    if (cmd.emit) begin
      out_char_r  <= char_c;
      out_index_r <= idx_r;
      out_last_r  <= last_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign stat.empty     = (len_c == '0);
  assign stat.last      = last_c;
  assign stat.slot_free = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign out_out_char   = out_char_r;
  assign out_char_index = out_index_r;
  assign out_is_last    = out_last_r;

endmodule

/* rtl/core/hex_field_formatter_top.sv */
// Top level of the hex field formatter: controller plus datapath.
//
// The block turns one 64-bit value, together with printf-style width,
// precision and flag bits, into right-justified hexadecimal text. Each input
// beat on the in_ channel (valid/ready) produces a run of output beats on the
// out_ channel, one ASCII byte per beat, with its position in the run and a
// marker on the final byte. A run holds at most 64 bytes; a zero value with
// an explicit zero precision and no padding gives no beat at all.
// After an input beat is accepted the block counts the significant nibbles,
// then lays out the field, then emits the first byte into the output register.
// Bytes then follow at one per cycle while the receiver keeps out_ready high.
// The output register paces the run: one byte is produced per cycle in which
// that register is empty or being drained.
// in_ready is high only while no run is being produced; the next item may be
// accepted while the final byte of the previous run still waits in the
// output register. If the receiver stalls, the current byte holds steady
// and the run pauses without loss.
// Reset (rst_n low, synchronous) returns the controller to idle and empties
// the output register; no other state survives between items.
module hex_field_formatter_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [hff_pkg::ValueW-1:0]   in_value,
  input  logic [hff_pkg::WidthW-1:0]   in_field_width,
  input  logic [hff_pkg::PrecW-1:0]    in_precision,
  input  logic                         in_has_precision,
  input  logic                         in_pad_with_zero,
  input  logic                         in_alternate_form,
  input  logic                         in_sign_slot,
  input  logic                         in_upper_case,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [7:0]                   out_out_char,
  output logic [hff_pkg::IndexW-1:0]   out_char_index,
  output logic                         out_is_last
);

  // Commands flow from the controller to the datapath, status flows back.
  hff_pkg::cmd_t  cmd;
  hff_pkg::stat_t stat;

  hff_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  hff_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_value          (in_value),
    .in_field_width    (in_field_width),
    .in_precision      (in_precision),
    .in_has_precision  (in_has_precision),
    .in_pad_with_zero  (in_pad_with_zero),
    .in_alternate_form (in_alternate_form),
    .in_sign_slot      (in_sign_slot),
    .in_upper_case     (in_upper_case),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_out_char      (out_out_char),
    .out_char_index    (out_char_index),
    .out_is_last       (out_is_last)
  );

  // An accepted item always takes the block out of idle: input is not ready right after it.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input still ready right after an accepted beat");

  // While a byte that is not the last one is pending, no new item may enter.
  a_no_accept_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_is_last) |-> !in_ready)
    else $error("input ready in the middle of a run");

  // Taking a byte that is not the last one brings its successor at once.
  a_run_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_is_last) |=>
      (out_valid && (out_char_index == hff_pkg::IndexW'($past(out_char_index) + 1'b1))))
    else $error("run did not advance to the next byte");

endmodule
